/* hw/rtl/assert_macros.svh */
// assertion macros shared by the sine and cosine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hw/rtl/fpsc_pkg.sv */
// types and constants of the fixed-point sine and cosine block
package fpsc_pkg;

  localparam int AngleW = 32;
  localparam int ValueW = 34;

  // 4/pi with 32 fractional bits
  localparam logic [32:0] FourOverPi = 33'h1_45f3_06dd;
  localparam logic [32:0] OneQ32     = 33'h1_0000_0000;
  localparam logic [31:0] SqrtHalf   = 32'hb504_f334;
  localparam logic [31:0] SinLead    = 32'hc90f_daa2;

  typedef logic [31:0] coef_arr_t [4];

  // horner coefficients, innermost first
  localparam coef_arr_t SinCoef = '{32'h0231_7888, 32'h03c2_857c,
                                    32'h07e5_4b84, 32'h14ab_bce6};
  localparam coef_arr_t CosCoef = '{32'h02d1_e41d, 32'h0543_87ad,
                                    32'h0d28_d331, 32'h4ef4_f327};

  typedef struct packed {
    logic special;
    logic use_cos;
    logic flip;
  } ctl_t;

  // reduced argument from the range stage
  typedef struct packed {
    logic [31:0] frac;
    ctl_t        ctl;
  } red_t;

  // unsigned polynomial result with its sign control
  typedef struct packed {
    logic [32:0] res;
    ctl_t        ctl;
  } poly_t;

endpackage

/* hw/rtl/fpsc_in_if.sv */
// input channel: command and angle word
interface fpsc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [fpsc_pkg::AngleW-1:0] angle;

  modport source (output valid, command, angle, input ready);
  modport sink (input valid, command, angle, output ready);
endinterface

/* hw/rtl/fpsc_out_if.sv */
// result channel: sine or cosine value word
interface fpsc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpsc_pkg::ValueW-1:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

/* hw/rtl/fpsc_range.sv */
// range reduction: magnitude, scale by 4/pi, octant split and reflection
`include "assert_macros.svh"

module fpsc_range (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic signed [fpsc_pkg::AngleW-1:0] in_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fpsc_pkg::red_t                      out_data
);
  import fpsc_pkg::*;

  localparam int NStg = 3;

  logic [NStg-1:0] v_r;
  logic [NStg-1:0] ld;

  logic        s1_cmd_r, s1_neg_r;
  logic [31:0] s1_mag_r;
  logic [31:0] ang_u;
  logic [31:0] mag_nxt;

  logic        s2_cmd_r, s2_neg_r;
  logic [2:0]  s2_oct_r;
  logic [31:0] s2_frac_r;
  logic [64:0] prod;

  red_t        s3_r;
  red_t        s3_nxt;
  logic [32:0] refl;
  logic [2:0]  oct_p1, oct_p2;

  // stage load enables, each stage fills when empty or moving on
  always_comb begin
    ld[NStg-1] = !v_r[NStg-1] || out_ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[NStg-1];
  assign out_data  = s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NStg; k++) begin
        if (ld[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // magnitude; the most negative angle comes out as 2^31
  assign ang_u   = in_angle;
  assign mag_nxt = ang_u[31] ? (32'd0 - ang_u) : ang_u;

  // scale by 4/pi
  assign prod = {33'd0, s1_mag_r} * {32'd0, FourOverPi};

  // reflect odd octants and pick polynomial and sign
  assign refl   = OneQ32 - {1'b0, s2_frac_r};
  assign oct_p1 = s2_oct_r + 3'd1;
  assign oct_p2 = s2_oct_r + 3'd2;

  always_comb begin
    s3_nxt.frac        = s2_oct_r[0] ? refl[31:0] : s2_frac_r;
    s3_nxt.ctl.special = s2_oct_r[0] && (s2_frac_r == 32'd0);
    s3_nxt.ctl.use_cos = oct_p1[1] ^ s2_cmd_r;
    s3_nxt.ctl.flip    = s2_cmd_r ? oct_p2[2] : (s2_oct_r[2] ^ s2_neg_r);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_cmd_r <= in_command;
      s1_neg_r <= ang_u[31];
      s1_mag_r <= mag_nxt;
    end
    if (ld[1]) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_neg_r  <= s1_neg_r;
      s2_oct_r  <= prod[46:44];
      s2_frac_r <= prod[43:12];
    end
    if (ld[2]) begin
      s3_r <= s3_nxt;
    end
  end

  // a stalled reduced word must hold until taken
  `ASSERT_NXT(a_red_hold, clk, rst_n, v_r[NStg-1] && !out_ready, v_r[NStg-1] && $stable(s3_r), "reduced word changed while stalled")

endmodule

/* hw/rtl/fpsc_poly.sv */
// polynomial pipeline: horner evaluation of sine or cosine on the fraction
`include "assert_macros.svh"

module fpsc_poly (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fpsc_pkg::red_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fpsc_pkg::poly_t  out_data
);
  import fpsc_pkg::*;

  localparam int NStg = 6;

  // high word of an unsigned product, product below 2^64
  function automatic logic [31:0] mulhi(input logic [32:0] a, input logic [31:0] b);
    logic [64:0] m;
    m = {32'd0, a} * {33'd0, b};
    return m[63:32];
  endfunction

  logic [NStg-1:0] v_r;
  logic [NStg-1:0] ld;

  // stage 1: square
  logic [31:0] p1_f_r, p1_sq_r;
  ctl_t        p1_ctl_r;
  // stage 2: coefficient terms
  logic [31:0] p2_f_r;
  logic [31:0] p2_t_r [4];
  logic [31:0] t_nxt  [4];
  ctl_t        p2_ctl_r;
  // stages 3 to 5: horner steps
  logic [31:0] p3_f_r, p3_p_r, p3_t2_r, p3_t3_r;
  ctl_t        p3_ctl_r;
  logic [31:0] p4_f_r, p4_p_r, p4_t3_r;
  ctl_t        p4_ctl_r;
  logic [31:0] p5_f_r, p5_p_r;
  ctl_t        p5_ctl_r;
  // stage 6: final term
  poly_t       p6_r;
  poly_t       p6_nxt;

  logic [32:0] a1, a2, a3, cos_res;
  logic [31:0] a4;

  // stage load enables
  always_comb begin
    ld[NStg-1] = !v_r[NStg-1] || out_ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[NStg-1];
  assign out_data  = p6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NStg; k++) begin
        if (ld[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // the four coefficient terms are independent of each other
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t_nxt[i] = mulhi({1'b0, p1_sq_r}, p1_ctl_r.use_cos ? CosCoef[i] : SinCoef[i]);
    end
  end

  assign a1 = OneQ32 - {1'b0, p2_t_r[0]};
  assign a2 = OneQ32 - {1'b0, p3_p_r};
  assign a3 = OneQ32 - {1'b0, p4_p_r};

  // last step: cosine ends on a subtract, sine multiplies back by the fraction
  assign a4      = SinLead - p5_p_r;
  assign cos_res = OneQ32 - {1'b0, p5_p_r};

  always_comb begin
    p6_nxt.ctl = p5_ctl_r;
    if (p5_ctl_r.special) begin
      p6_nxt.res = {1'b0, SqrtHalf};
    end else if (p5_ctl_r.use_cos) begin
      p6_nxt.res = cos_res;
    end else begin
      p6_nxt.res = {1'b0, mulhi({1'b0, a4}, p5_f_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p1_f_r   <= in_data.frac;
      p1_sq_r  <= mulhi({1'b0, in_data.frac}, in_data.frac);
      p1_ctl_r <= in_data.ctl;
    end
    if (ld[1]) begin
      p2_f_r   <= p1_f_r;
      p2_t_r   <= t_nxt;
      p2_ctl_r <= p1_ctl_r;
    end
    if (ld[2]) begin
      p3_f_r   <= p2_f_r;
      p3_p_r   <= mulhi(a1, p2_t_r[1]);
      p3_t2_r  <= p2_t_r[2];
      p3_t3_r  <= p2_t_r[3];
      p3_ctl_r <= p2_ctl_r;
    end
    if (ld[3]) begin
      p4_f_r   <= p3_f_r;
      p4_p_r   <= mulhi(a2, p3_t2_r);
      p4_t3_r  <= p3_t3_r;
      p4_ctl_r <= p3_ctl_r;
    end
    if (ld[4]) begin
      p5_f_r   <= p4_f_r;
      p5_p_r   <= mulhi(a3, p4_t3_r);
      p5_ctl_r <= p4_ctl_r;
    end
    if (ld[5]) begin
      p6_r <= p6_nxt;
    end
  end

  // the sine polynomial never reaches one
  `ASSERT_IMP(a_sine_below_one, clk, rst_n, v_r[NStg-1] && !p6_r.ctl.use_cos, p6_r.res[32] == 1'b0, "sine result reached one")
  // the exact octant boundary answers sqrt(1/2)
  `ASSERT_IMP(a_special_value, clk, rst_n, v_r[NStg-1] && p6_r.ctl.special, p6_r.res == {1'b0, SqrtHalf}, "boundary result is not sqrt(1/2)")

endmodule

/* hw/rtl/fixed_point_sine_cosine.sv */
// Fixed-point sine and cosine of an angle in radians.
//
// Input channel in_if: one word per item, command (0 sine, 1 cosine) and
// a signed angle with 12 fractional bits. Result channel out_if: one word
// per item, the signed value with 32 fractional bits, range -1.0 .. +1.0.
// Both channels move a word at a clock edge where valid and ready are high.
//
// Ten register stages: three range reduction stages, six polynomial stages
// (one multiply deep each) and the output register that applies the sign.
// A new word is taken every cycle unless a stall has filled every stage.
//
// When the receiver holds ready low the words queue up in the pipeline;
// each stage fills an empty slot ahead of it, so up to 10 words sit in
// flight and none is lost or repeated. in_if.ready drops only once every
// stage holds a word. Reset (rst_n low, synchronous) empties the pipeline;
// the block keeps no other state.
`include "assert_macros.svh"

module fixed_point_sine_cosine (
  input  logic        clk,
  input  logic        rst_n,
  fpsc_in_if.sink     in_if,
  fpsc_out_if.source  out_if
);
  import fpsc_pkg::*;

  logic  rng_valid, rng_ready;
  red_t  rng_data;
  logic  pol_valid, pol_ready;
  poly_t pol_data;

  logic              out_v_r;
  logic [ValueW-1:0] out_value_r;
  logic [ValueW-1:0] value_nxt;
  logic              out_ld;

  fpsc_range u_range (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_command (in_if.command),
    .in_angle   (in_if.angle),
    .out_valid  (rng_valid),
    .out_ready  (rng_ready),
    .out_data   (rng_data)
  );

  fpsc_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rng_valid),
    .in_ready  (rng_ready),
    .in_data   (rng_data),
    .out_valid (pol_valid),
    .out_ready (pol_ready),
    .out_data  (pol_data)
  );

  // output register, loads when empty or when the word is taken
  assign out_ld    = !out_v_r || out_if.ready;
  assign pol_ready = out_ld;

  // apply the sign
  assign value_nxt = pol_data.ctl.flip ? (34'd0 - {1'b0, pol_data.res})
                                       : {1'b0, pol_data.res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ld) begin
      out_v_r <= pol_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_value_r <= value_nxt;
    end
  end

  assign out_if.valid = out_v_r;
  assign out_if.value = out_value_r;

  // result magnitude never exceeds one
  `ASSERT_IMP(a_value_range, clk, rst_n, out_v_r, out_value_r[ValueW-1:ValueW-2] != 2'b10, "result out of range")

endmodule

/* bench/tb_top.sv */
// self-checking bench for the fixed-point sine and cosine block, with its own predictor
module tb_top;

  // command codes
  localparam logic CmdSine   = 1'b0;
  localparam logic CmdCosine = 1'b1;

  // arithmetic constants, q32 unless noted
  localparam logic [63:0] UnitQ32       = 64'h1_0000_0000;
  localparam logic [63:0] RootHalfQ32   = 64'hb504_f334;
  localparam logic [63:0] QuarterPiQ32  = 64'hc90f_daa2;
  localparam logic [63:0] FourOverPiQ33 = 64'h1_45f3_06dd;
  // horner terms, innermost at index 0
  localparam logic [3:0][31:0] SinTerms = {32'h14ab_bce6, 32'h07e5_4b84,
                                           32'h03c2_857c, 32'h0231_7888};
  localparam logic [3:0][31:0] CosTerms = {32'h4ef4_f327, 32'h0d28_d331,
                                           32'h0543_87ad, 32'h02d1_e41d};

  localparam int DutLatency  = 10;
  localparam int RandomItems = 1350;
  localparam int CycleLimit  = 200000;

  typedef struct {
    logic        command;
    logic [31:0] angle;
  } angle_req_t;

  typedef struct {
    logic        command;
    logic [31:0] angle;
    logic [33:0] value;
  } trig_expect_t;

  logic clk;
  logic rst_n;

  fpsc_in_if  in_ch ();
  fpsc_out_if out_ch ();

  fixed_point_sine_cosine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  angle_req_t   pending_angles[$];
  trig_expect_t expected_values[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           word_taken = 1'b0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_left = 0;

  // polynomial on a fraction in [0, 1] of one octant, 64-bit wrapping arithmetic
  function automatic logic [63:0] octant_poly(input logic [63:0] f, input logic cos_poly);
    logic [3:0][31:0] terms;
    logic [63:0] sq;
    logic [63:0] acc;
    if (f == UnitQ32) return RootHalfQ32;
    terms = cos_poly ? CosTerms : SinTerms;
    sq = (f * f) >> 32;
    acc = UnitQ32 - ((sq * terms[0]) >> 32);
    for (int i = 1; i < 3; i++)
      acc = UnitQ32 - ((acc * ((sq * terms[i]) >> 32)) >> 32);
    if (cos_poly) return UnitQ32 - ((acc * ((sq * terms[3]) >> 32)) >> 32);
    acc = QuarterPiQ32 - ((acc * ((sq * terms[3]) >> 32)) >> 32);
    return (acc * f) >> 32;
  endfunction

  // expected value word for one command and angle
  function automatic logic [33:0] predict_sine_cosine(input logic cmd, input logic [31:0] raw);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] frac;
    logic [63:0] res;
    logic [2:0]  oct;
    logic [2:0]  oct_up1;
    logic [2:0]  oct_up2;
    logic        cos_poly;
    logic        flip;
    neg = raw[31];
    mag = neg ? {32'd0, 32'd0 - raw} : {32'd0, raw};
    // most negative angle counts as 2^31
    if (neg && mag == 64'd0) mag = 64'h8000_0000;
    prod = mag * FourOverPiQ33;
    oct = prod[46:44];
    frac = {32'd0, prod[43:12]};
    // odd octants run backwards
    if (oct[0]) frac = UnitQ32 - frac;
    oct_up1 = oct + 3'd1;
    oct_up2 = oct + 3'd2;
    cos_poly = oct_up1[1] ^ (cmd == CmdCosine);
    res = octant_poly(frac, cos_poly);
    if (cmd == CmdCosine) flip = oct_up2[2];
    else flip = oct[2] ^ neg;
    if (flip) res = 64'd0 - res;
    return res[33:0];
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic queue_angle(input logic cmd, input logic [31:0] ang);
    angle_req_t req;
    req.command = cmd;
    req.angle = ang;
    pending_angles.push_back(req);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // monitor: predict accepted words, check result words
  always @(posedge clk) begin
    trig_expect_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want.command = in_ch.command;
        want.angle = in_ch.angle;
        want.value = predict_sine_cosine(in_ch.command, in_ch.angle);
        expected_values.push_back(want);
        word_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", out_ch.value));
        end else begin
          want = expected_values.pop_front();
          if (out_ch.value !== want.value)
            report_mismatch($sformatf("cmd %0d angle %h: value %h, expected %h",
                                      want.command, want.angle, out_ch.value, want.value));
        end
      end
    end
  end

  // driver: bursts of words with random gaps between them
  always @(negedge clk) begin
    if (rst_n && !(in_ch.valid && !word_taken)) begin
      if (word_taken) begin
        void'(pending_angles.pop_front());
        word_taken = 1'b0;
      end
      if (gap_left != 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_angles.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.command <= pending_angles[0].command;
        in_ch.angle <= pending_angles[0].angle;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern chosen by bits 9:8 of the cycle count
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      case (cycle_count[9:8])
        2'd1: if ($urandom_range(3) == 0) stall_left = 1;
        2'd2: if ($urandom_range(15) == 0) stall_left = $urandom_range(4, 14);
        2'd3: stall_left = $urandom_range(0, 2);
        default: stall_left = 0;
      endcase
    end
  end

  // stimulus and end of run
  initial begin
    logic        cmd;
    logic [31:0] ang;
    int          pick;
    longint      k;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CmdSine;
    in_ch.angle = '0;
    out_ch.ready = 1'b0;

    // directed: extremes, octant edges near multiples of pi/4, large angles
    for (int c = 0; c < 2; c++) begin
      cmd = (c == 0) ? CmdSine : CmdCosine;
      queue_angle(cmd, 32'd0);
      queue_angle(cmd, 32'd1);
      queue_angle(cmd, 32'hffff_ffff);
      queue_angle(cmd, 32'h7fff_ffff);
      queue_angle(cmd, 32'h8000_0000);
      queue_angle(cmd, 32'd3217);
      queue_angle(cmd, 32'd0 - 32'd3217);
      queue_angle(cmd, 32'd6434);
      queue_angle(cmd, 32'd9651);
      queue_angle(cmd, 32'd0 - 32'd12868);
      queue_angle(cmd, 32'd25736);
      queue_angle(cmd, 32'h4000_0000);
    end

    // random: full range, one turn either way, near octant edges, extremes
    for (int n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(99);
      cmd = $urandom_range(1) ? CmdCosine : CmdSine;
      if (pick < 40) begin
        ang = $urandom;
      end else if (pick < 65) begin
        ang = $urandom_range(0, 2 * 25736) - 25736;
      end else if (pick < 85) begin
        k = longint'($urandom_range(0, 1334000)) - 667000;
        k = k * 64'sd3216990877 / 64'sd1000000 + longint'($urandom_range(0, 6)) - 3;
        ang = k[31:0];
      end else begin
        case ($urandom_range(5))
          0: ang = 32'h8000_0000 + $urandom_range(0, 3);
          1: ang = 32'h7fff_ffff - $urandom_range(0, 3);
          2: ang = $urandom_range(0, 15);
          3: ang = 32'd0 - $urandom_range(1, 16);
          4: ang = 32'd1 << $urandom_range(0, 31);
          default: ang = ~(32'd1 << $urandom_range(0, 31));
        endcase
      end
      queue_angle(cmd, ang);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain: all words sent, all results back, then a quiet spell
    while (pending_angles.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_values.size() != 0) @(posedge clk);
    repeat (2 * DutLatency) @(posedge clk);

    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/fpsc_pkg.sv
hw/rtl/fpsc_in_if.sv
hw/rtl/fpsc_out_if.sv
hw/rtl/fpsc_range.sv
hw/rtl/fpsc_poly.sv
hw/rtl/fixed_point_sine_cosine.sv
bench/tb_top.sv
